// ===== sv/universal_machine_execute_unit_macros.svh =====
// ----------------------------------------------------------------------------
// universal machine execute unit assertion macros
// clocked assertion helpers for the rtl file that carries checks
// ----------------------------------------------------------------------------
`ifndef UNIVERSAL_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define UNIVERSAL_MACHINE_EXECUTE_UNIT_MACROS_SVH

// property checked at every rising edge outside reset
`define UM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen at a rising edge outside reset
`define UM_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/um_pkg.sv =====
// ----------------------------------------------------------------------------
// um_pkg
// shared widths, constants and codes of the universal machine execute unit
// ----------------------------------------------------------------------------
package um_pkg;

    localparam int WORD_W       = 32;
    localparam int CHAR_W       = 8;
    localparam int NUM_REGS_DEF = 8;
    localparam int REG_AW       = 3;
    localparam int OPC_LSB      = 28;
    localparam int OPC_W        = 4;
    localparam int IMM_A_LSB    = 25;
    localparam int IMM_W        = 25;
    localparam int FLD_A_LSB    = 6;
    localparam int FLD_B_LSB    = 3;
    localparam int FLD_C_LSB    = 0;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [OPC_W-1:0] {
        OP_CMOV  = 4'd0,
        OP_LOAD  = 4'd1,
        OP_STORE = 4'd2,
        OP_ADD   = 4'd3,
        OP_MUL   = 4'd4,
        OP_DIV   = 4'd5,
        OP_NAND  = 4'd6,
        OP_HALT  = 4'd7,
        OP_MAP   = 4'd8,
        OP_UNMAP = 4'd9,
        OP_OUT   = 4'd10,
        OP_IN    = 4'd11,
        OP_JUMP  = 4'd12,
        OP_IMM   = 4'd13
    } opcode_t;

    typedef enum logic [3:0] {
        ACT_NONE    = 4'd0,
        ACT_READ    = 4'd1,
        ACT_WRITE   = 4'd2,
        ACT_MAP     = 4'd3,
        ACT_UNMAP   = 4'd4,
        ACT_OUTCHAR = 4'd5,
        ACT_INPUT   = 4'd6,
        ACT_PROG    = 4'd7,
        ACT_HALT    = 4'd8,
        ACT_FAULT   = 4'd9
    } action_t;

    typedef enum logic [1:0] {
        FLT_NONE       = 2'd0,
        FLT_BAD_OP     = 2'd1,
        FLT_DIV_ZERO   = 2'd2,
        FLT_UNEXPECTED = 2'd3
    } fault_t;

    typedef enum logic [1:0] {
        KIND_INSTR      = 2'd0,
        KIND_MEM_REPLY  = 2'd1,
        KIND_CHAR_REPLY = 2'd2
    } kind_t;

endpackage

// ===== sv/um_regfile.sv =====
// ----------------------------------------------------------------------------
// um_regfile
// general register file: two synchronous copies, registered reads
// ----------------------------------------------------------------------------
module um_regfile
    import um_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF,
    localparam int AW      = $clog2(NUM_REGS)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    input  logic [AW-1:0] rd_addr_c,
    output word_t         rd_data_a,
    output word_t         rd_data_b,
    output word_t         rd_data_c,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  word_t         wr_data
);

    // copy bc serves the b and c ports, copy a the a port
    word_t bank_bc_mem [NUM_REGS];
    word_t bank_a_mem  [NUM_REGS];

    logic [NUM_REGS-1:0] vld_reg;
    word_t               rda_reg;
    word_t               rdb_reg;
    word_t               rdc_reg;
    logic                vlda_reg;
    logic                vldb_reg;
    logic                vldc_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bank_bc_mem[wr_addr] <= wr_data;
            bank_a_mem[wr_addr]  <= wr_data;
        end
        if (rd_en)
        begin
            rda_reg <= bank_a_mem[rd_addr_a];
            rdb_reg <= bank_bc_mem[rd_addr_b];
            rdc_reg <= bank_bc_mem[rd_addr_c];
        end
    end

    // an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            vlda_reg <= 1'b0;
            vldb_reg <= 1'b0;
            vldc_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                vlda_reg <= vld_reg[rd_addr_a];
                vldb_reg <= vld_reg[rd_addr_b];
                vldc_reg <= vld_reg[rd_addr_c];
            end
        end
    end

    assign rd_data_a = vlda_reg ? rda_reg : '0;
    assign rd_data_b = vldb_reg ? rdb_reg : '0;
    assign rd_data_c = vldc_reg ? rdc_reg : '0;

endmodule

// ===== sv/um_div.sv =====
// ----------------------------------------------------------------------------
// um_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module um_div
    import um_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t dividend,
    input  word_t divisor,
    output logic  done,
    output word_t quotient
);

    localparam int CW = $clog2(WORD_W);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    word_t         rem_reg;
    word_t         quo_reg;
    word_t         dvs_reg;

    logic [WORD_W:0] shifted;
    logic [WORD_W:0] diff;
    logic            take;
    word_t           rem_next;
    word_t           quo_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[WORD_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        take     = !diff[WORD_W];
        rem_next = take ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
        quo_next = {quo_reg[WORD_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(WORD_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/universal_machine_execute_unit.sv =====
// ----------------------------------------------------------------------------
// universal_machine_execute_unit
// executes universal machine instructions and takes segment and input replies
// ----------------------------------------------------------------------------
// One item is in flight at a time. An item is taken in while the register
// file is read, then executed, and replies, faults and most instructions
// commit from the execute step. Multiply registers its product and commits
// from the commit step, and divide runs the 32-step restoring divider
// before the commit step. A result waiting on a stalled output holds the unit
// in its commit step until it is taken. Segment load, map and input
// requests leave a reply pending that the next item must complete.
`include "universal_machine_execute_unit_macros.svh"

module universal_machine_execute_unit
    import um_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  word_t             instr_word,
    input  word_t             reply_data,
    input  logic [CHAR_W-1:0] in_char,
    input  logic              in_eof,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [3:0]        action,
    output word_t             seg_id,
    output word_t             offset,
    output word_t             write_data,
    output logic [CHAR_W-1:0] out_char,
    output word_t             next_pc,
    output logic [1:0]        fault_code
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_COMMIT
    } state_t;

    typedef struct packed {
        action_t           action;
        word_t             seg_id;
        word_t             offset;
        word_t             wdata;
        logic [CHAR_W-1:0] ochar;
        word_t             npc;
        fault_t            fault;
        logic              wr_en;
        logic [REG_AW-1:0] wr_addr;
        word_t             wr_data;
        logic              pend_set;
        logic              pend_clr;
        logic [REG_AW-1:0] pend_dest;
        logic              pend_input;
        logic              use_mul;
        logic              use_div;
    } res_t;

    state_t state_reg, state_next;
    word_t  pc_reg, pc_next;
    logic   pend_reg, pend_next;
    logic   pend_input_reg, pend_input_next;
    logic [REG_AW-1:0] pend_dest_reg, pend_dest_next;

    logic [1:0]        kind_reg, kind_next;
    word_t             word_reg, word_next;
    word_t             rdata_reg, rdata_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              eof_reg, eof_next;

    res_t res_reg, res_next;

    logic              out_valid_reg, out_valid_next;
    logic [3:0]        action_reg, action_next;
    word_t             seg_id_reg, seg_id_next;
    word_t             offset_reg, offset_next;
    word_t             wdata_reg, wdata_next;
    logic [CHAR_W-1:0] ochar_reg, ochar_next;
    word_t             npc_reg, npc_next;
    logic [1:0]        fault_reg, fault_next;

    logic    in_fire;
    logic    out_free;
    logic    commit_fire;
    res_t    commit_res;
    res_t    exec_res;
    opcode_t op;
    word_t   ra;
    word_t   rb;
    word_t   rc;
    word_t   mul_lo;
    logic    div_start;
    logic    div_done;
    word_t   div_quo;
    logic    rf_we;

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign rf_we    = commit_fire && commit_res.wr_en;

    // reads are issued only as an item is taken, writes only at commit
    um_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_fire),
        .rd_addr_a (instr_word[FLD_A_LSB +: REG_AW]),
        .rd_addr_b (instr_word[FLD_B_LSB +: REG_AW]),
        .rd_addr_c (instr_word[FLD_C_LSB +: REG_AW]),
        .rd_data_a (ra),
        .rd_data_b (rb),
        .rd_data_c (rc),
        .wr_en     (rf_we),
        .wr_addr   (commit_res.wr_addr),
        .wr_data   (commit_res.wr_data)
    );

    um_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rb),
        .divisor  (rc),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign mul_lo = rb * rc;
    assign op     = opcode_t'(word_reg[OPC_LSB +: OPC_W]);

    // execute step: decode the held item against the register read data
    always_comb
    begin
        exec_res     = '0;
        exec_res.npc = pc_reg + 1'b1;
        if (kind_reg != KIND_INSTR)
        begin
            exec_res.npc = pc_reg;
            if (!pend_reg || (kind_reg != KIND_MEM_REPLY && kind_reg != KIND_CHAR_REPLY)
                || ((kind_reg == KIND_CHAR_REPLY) != pend_input_reg))
            begin
                exec_res.action = ACT_FAULT;
                exec_res.fault  = FLT_UNEXPECTED;
            end
            else
            begin
                exec_res.wr_en    = 1'b1;
                exec_res.wr_addr  = pend_dest_reg;
                exec_res.pend_clr = 1'b1;
                if (kind_reg == KIND_MEM_REPLY)
                begin
                    exec_res.wr_data = rdata_reg;
                end
                else
                begin
                    exec_res.wr_data = eof_reg ? '1
                                               : {{(WORD_W-CHAR_W){1'b0}}, char_reg};
                end
            end
        end
        else if (pend_reg)
        begin
            exec_res.npc    = pc_reg;
            exec_res.action = ACT_FAULT;
            exec_res.fault  = FLT_UNEXPECTED;
        end
        else
        begin
            unique case (op)
                OP_CMOV:
                begin
                    exec_res.wr_en   = (rc != '0);
                    exec_res.wr_addr = word_reg[FLD_A_LSB +: REG_AW];
                    exec_res.wr_data = rb;
                end
                OP_LOAD:
                begin
                    exec_res.action     = ACT_READ;
                    exec_res.seg_id     = rb;
                    exec_res.offset     = rc;
                    exec_res.pend_set   = 1'b1;
                    exec_res.pend_dest  = word_reg[FLD_A_LSB +: REG_AW];
                end
                OP_STORE:
                begin
                    exec_res.action = ACT_WRITE;
                    exec_res.seg_id = ra;
                    exec_res.offset = rb;
                    exec_res.wdata  = rc;
                end
                OP_ADD:
                begin
                    exec_res.wr_en   = 1'b1;
                    exec_res.wr_addr = word_reg[FLD_A_LSB +: REG_AW];
                    exec_res.wr_data = rb + rc;
                end
                OP_MUL:
                begin
                    exec_res.wr_en   = 1'b1;
                    exec_res.wr_addr = word_reg[FLD_A_LSB +: REG_AW];
                    exec_res.use_mul = 1'b1;
                end
                OP_DIV:
                begin
                    if (rc == '0)
                    begin
                        exec_res.action = ACT_FAULT;
                        exec_res.fault  = FLT_DIV_ZERO;
                        exec_res.npc    = pc_reg;
                    end
                    else
                    begin
                        exec_res.wr_en   = 1'b1;
                        exec_res.wr_addr = word_reg[FLD_A_LSB +: REG_AW];
                        exec_res.use_div = 1'b1;
                    end
                end
                OP_NAND:
                begin
                    exec_res.wr_en   = 1'b1;
                    exec_res.wr_addr = word_reg[FLD_A_LSB +: REG_AW];
                    exec_res.wr_data = ~(rb & rc);
                end
                OP_HALT:
                begin
                    exec_res.action = ACT_HALT;
                end
                OP_MAP:
                begin
                    exec_res.action    = ACT_MAP;
                    exec_res.offset    = rc;
                    exec_res.pend_set  = 1'b1;
                    exec_res.pend_dest = word_reg[FLD_B_LSB +: REG_AW];
                end
                OP_UNMAP:
                begin
                    exec_res.action = ACT_UNMAP;
                    exec_res.seg_id = rc;
                end
                OP_OUT:
                begin
                    exec_res.action = ACT_OUTCHAR;
                    exec_res.ochar  = rc[CHAR_W-1:0];
                end
                OP_IN:
                begin
                    exec_res.action     = ACT_INPUT;
                    exec_res.pend_set   = 1'b1;
                    exec_res.pend_dest  = word_reg[FLD_C_LSB +: REG_AW];
                    exec_res.pend_input = 1'b1;
                end
                OP_JUMP:
                begin
                    // a zero segment is a plain jump within the running program
                    if (rb != '0)
                    begin
                        exec_res.action = ACT_PROG;
                        exec_res.seg_id = rb;
                    end
                    exec_res.npc = rc;
                end
                OP_IMM:
                begin
                    exec_res.wr_en   = 1'b1;
                    exec_res.wr_addr = word_reg[IMM_A_LSB +: REG_AW];
                    exec_res.wr_data = {{(WORD_W-IMM_W){1'b0}}, word_reg[IMM_W-1:0]};
                end
                default:
                begin
                    exec_res.action = ACT_FAULT;
                    exec_res.fault  = FLT_BAD_OP;
                    exec_res.npc    = pc_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pc_next         = pc_reg;
        pend_next       = pend_reg;
        pend_input_next = pend_input_reg;
        pend_dest_next  = pend_dest_reg;
        kind_next       = kind_reg;
        word_next       = word_reg;
        rdata_next      = rdata_reg;
        char_next       = char_reg;
        eof_next        = eof_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && out_stall;
        action_next     = action_reg;
        seg_id_next     = seg_id_reg;
        offset_next     = offset_reg;
        wdata_next      = wdata_reg;
        ochar_next      = ochar_reg;
        npc_next        = npc_reg;
        fault_next      = fault_reg;
        div_start       = 1'b0;
        commit_fire     = 1'b0;
        commit_res      = res_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = kind;
                    word_next  = instr_word;
                    rdata_next = reply_data;
                    char_next  = in_char;
                    eof_next   = in_eof;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_res.use_mul)
                begin
                    res_next         = exec_res;
                    res_next.wr_data = mul_lo;
                    state_next       = S_COMMIT;
                end
                else if (exec_res.use_div)
                begin
                    res_next   = exec_res;
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else if (out_free)
                begin
                    commit_fire = 1'b1;
                    commit_res  = exec_res;
                    state_next  = S_IDLE;
                end
                else
                begin
                    res_next   = exec_res;
                    state_next = S_COMMIT;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next.wr_data = div_quo;
                    state_next       = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    commit_fire = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (commit_fire)
        begin
            pc_next        = commit_res.npc;
            out_valid_next = 1'b1;
            action_next    = commit_res.action;
            seg_id_next    = commit_res.seg_id;
            offset_next    = commit_res.offset;
            wdata_next     = commit_res.wdata;
            ochar_next     = commit_res.ochar;
            npc_next       = commit_res.npc;
            fault_next     = commit_res.fault;
            if (commit_res.pend_set)
            begin
                pend_next       = 1'b1;
                pend_dest_next  = commit_res.pend_dest;
                pend_input_next = commit_res.pend_input;
            end
            else if (commit_res.pend_clr)
            begin
                pend_next       = 1'b0;
                pend_input_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pc_reg         <= '0;
            pend_reg       <= 1'b0;
            pend_input_reg <= 1'b0;
            pend_dest_reg  <= '0;
            kind_reg       <= '0;
            word_reg       <= '0;
            rdata_reg      <= '0;
            char_reg       <= '0;
            eof_reg        <= 1'b0;
            res_reg        <= '0;
            out_valid_reg  <= 1'b0;
            action_reg     <= '0;
            seg_id_reg     <= '0;
            offset_reg     <= '0;
            wdata_reg      <= '0;
            ochar_reg      <= '0;
            npc_reg        <= '0;
            fault_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pc_reg         <= pc_next;
            pend_reg       <= pend_next;
            pend_input_reg <= pend_input_next;
            pend_dest_reg  <= pend_dest_next;
            kind_reg       <= kind_next;
            word_reg       <= word_next;
            rdata_reg      <= rdata_next;
            char_reg       <= char_next;
            eof_reg        <= eof_next;
            res_reg        <= res_next;
            out_valid_reg  <= out_valid_next;
            action_reg     <= action_next;
            seg_id_reg     <= seg_id_next;
            offset_reg     <= offset_next;
            wdata_reg      <= wdata_next;
            ochar_reg      <= ochar_next;
            npc_reg        <= npc_next;
            fault_reg      <= fault_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign action     = action_reg;
    assign seg_id     = seg_id_reg;
    assign offset     = offset_reg;
    assign write_data = wdata_reg;
    assign out_char   = ochar_reg;
    assign next_pc    = npc_reg;
    assign fault_code = fault_reg;

    `UM_ASSERT(a_commit_needs_room, commit_fire |-> (!out_valid_reg || !out_stall), "commit while output item is stalled")
    `UM_NEVER(a_rf_no_clash, rf_we && in_fire, "register write and read issue on the same edge")
    `UM_ASSERT(a_div_done_in_div, div_done |-> (state_reg == S_DIV), "divider finished outside the divide step")
    `UM_ASSERT(a_pend_action, (commit_fire && commit_res.pend_set) |=> (action_reg == ACT_READ || action_reg == ACT_MAP || action_reg == ACT_INPUT), "reply left pending by a non-request item")

endmodule
